[hdl/imgi_pkg.sv]
package imgi_pkg;

  localparam int MAX_WIDTH     = 256;
  localparam int MAX_HEIGHT    = 256;
  localparam int FRACTION_BITS = 8;

  localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam int DIM_W   = 9;
  localparam int POS_W   = 12;
  localparam int QUERY_W = 20;
  localparam int VAL_W   = 32;
  // signed neighbour coordinate, room for floor(q)+1 and for col/row
  localparam int COORD_W = ((QUERY_W - FRACTION_BITS > POS_W) ?
                            (QUERY_W - FRACTION_BITS) : POS_W) + 1;
  localparam int W_W     = 2 * FRACTION_BITS + 1;
  localparam int PROD_W  = VAL_W + W_W + 1;

  localparam int CMDQ_DEPTH = 2;

  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  typedef enum logic [1:0] {
    MODE_WRITE,
    MODE_INC,
    MODE_NULL,
    MODE_INTERP
  } mode_t;

  typedef enum logic [1:0] {
    REG_WIDTH,
    REG_HEIGHT,
    REG_OUT_VALUE,
    REG_OUT_NULL
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPD_WR,
    ST_INT_RD,
    ST_INT_END
  } state_t;

  typedef struct packed {
    mode_t                     mode;
    logic signed [POS_W-1:0]   col;
    logic signed [POS_W-1:0]   row;
    logic signed [VAL_W-1:0]   pixel_value;
    logic                      value_is_null;
    logic signed [QUERY_W-1:0] query_x;
    logic signed [QUERY_W-1:0] query_y;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] interp_value;
    logic                    interp_is_null;
  } out_item_t;

  typedef struct packed {
    logic [DIM_W-1:0]        image_width;
    logic [DIM_W-1:0]        image_height;
    logic signed [VAL_W-1:0] outside_value;
    logic                    outside_is_null;
  } cfg_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic              in_img;
    logic [W_W-1:0]    wgt;
  } nbr_t;

  // nbr[0] is the target pixel of an update, or a00; then a10, a01, a11
  typedef struct packed {
    mode_t                   mode;
    nbr_t [3:0]              nbr;
    logic signed [VAL_W-1:0] value;
    logic                    value_is_null;
  } cmd_t;

endpackage

[hdl/imgi_regs.sv]
module imgi_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [imgi_pkg::PADDR_W-1:0]  cfg_paddr,
  input  logic [imgi_pkg::PDATA_W-1:0]  cfg_pwdata,
  output logic [imgi_pkg::PDATA_W-1:0]  cfg_prdata,
  output logic                          cfg_pready,
  output imgi_pkg::cfg_t                cfg
);
  import imgi_pkg::*;

  cfg_t     cfg_r, cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign idx        = reg_idx_t'(cfg_paddr[3:2]);
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg        = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_WIDTH:     cfg_nxt.image_width     = cfg_pwdata[DIM_W-1:0];
        REG_HEIGHT:    cfg_nxt.image_height    = cfg_pwdata[DIM_W-1:0];
        REG_OUT_VALUE: cfg_nxt.outside_value   = cfg_pwdata[VAL_W-1:0];
        REG_OUT_NULL:  cfg_nxt.outside_is_null = cfg_pwdata[0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_WIDTH:     cfg_prdata = PDATA_W'(cfg_r.image_width);
      REG_HEIGHT:    cfg_prdata = PDATA_W'(cfg_r.image_height);
      REG_OUT_VALUE: cfg_prdata = PDATA_W'(cfg_r.outside_value);
      REG_OUT_NULL:  cfg_prdata = PDATA_W'(cfg_r.outside_is_null);
      default:       cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_width     <= DIM_W'(256);
      cfg_r.image_height    <= DIM_W'(256);
      cfg_r.outside_value   <= '0;
      cfg_r.outside_is_null <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

[hdl/imgi_front.sv]
module imgi_front (
  input  imgi_pkg::in_item_t in_item,
  input  imgi_pkg::cfg_t     cfg,
  output imgi_pkg::cmd_t     cmd
);
  import imgi_pkg::*;

  localparam logic [COORD_W-2:0] MAX_W_C = (COORD_W-1)'(MAX_WIDTH);
  localparam logic [COORD_W-2:0] MAX_H_C = (COORD_W-1)'(MAX_HEIGHT);
  localparam logic [ADDR_W-1:0]  MAX_W_A = ADDR_W'(MAX_WIDTH);
  localparam logic [FRACTION_BITS:0] S_C = (FRACTION_BITS+1)'(1 << FRACTION_BITS);
  localparam logic signed [COORD_W-1:0] ONE_C = COORD_W'(1);

  logic [COORD_W-2:0]          eff_w, eff_h, dim_w, dim_h;
  logic signed [COORD_W-1:0]   base_c, base_r, next_c, next_r;
  logic [FRACTION_BITS:0]      fx, fy, sx, sy;
  logic [2*FRACTION_BITS+1:0]  p00, p10, p01, p11;

  function automatic nbr_t locate(logic signed [COORD_W-1:0] c,
                                  logic signed [COORD_W-1:0] r,
                                  logic [COORD_W-2:0] ew,
                                  logic [COORD_W-2:0] eh);
    logic [ADDR_W-1:0] rr;
    logic [ADDR_W-1:0] cc;
    nbr_t              n;
    rr       = ADDR_W'(r[ROW_W-1:0]);
    cc       = ADDR_W'(c[COL_W-1:0]);
    n.addr   = rr * MAX_W_A + cc;
    n.in_img = !c[COORD_W-1] && !r[COORD_W-1] &&
               (c[COORD_W-2:0] < ew) && (r[COORD_W-2:0] < eh);
    n.wgt    = '0;
    return n;
  endfunction

  always_comb begin
    dim_w = (COORD_W-1)'(cfg.image_width);
    dim_h = (COORD_W-1)'(cfg.image_height);
    eff_w = (dim_w > MAX_W_C) ? MAX_W_C : dim_w;
    eff_h = (dim_h > MAX_H_C) ? MAX_H_C : dim_h;

    fx  = {1'b0, in_item.query_x[FRACTION_BITS-1:0]};
    fy  = {1'b0, in_item.query_y[FRACTION_BITS-1:0]};
    sx  = S_C - fx;
    sy  = S_C - fy;
    p00 = sx * sy;
    p10 = fx * sy;
    p01 = sx * fy;
    p11 = fx * fy;

    if (in_item.mode == MODE_INTERP) begin
      base_c = COORD_W'(in_item.query_x >>> FRACTION_BITS);
      base_r = COORD_W'(in_item.query_y >>> FRACTION_BITS);
    end else begin
      base_c = COORD_W'(in_item.col);
      base_r = COORD_W'(in_item.row);
    end
    next_c = base_c + ONE_C;
    next_r = base_r + ONE_C;

    cmd.mode          = in_item.mode;
    cmd.value         = in_item.pixel_value;
    cmd.value_is_null = in_item.value_is_null;
    cmd.nbr[0]        = locate(base_c, base_r, eff_w, eff_h);
    cmd.nbr[1]        = locate(next_c, base_r, eff_w, eff_h);
    cmd.nbr[2]        = locate(base_c, next_r, eff_w, eff_h);
    cmd.nbr[3]        = locate(next_c, next_r, eff_w, eff_h);
    cmd.nbr[0].wgt    = p00[W_W-1:0];
    cmd.nbr[1].wgt    = p10[W_W-1:0];
    cmd.nbr[2].wgt    = p01[W_W-1:0];
    cmd.nbr[3].wgt    = p11[W_W-1:0];
  end

endmodule

[hdl/imgi_cmdq.sv]
module imgi_cmdq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  imgi_pkg::cmd_t wr_cmd,
  output logic           full,
  input  logic           pop,
  output imgi_pkg::cmd_t head,
  output logic           empty
);
  import imgi_pkg::*;

  localparam int PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(CMDQ_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CMDQ_DEPTH);

  cmd_t             slot_r [CMDQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == FULL_CNT);
  assign empty   = (cnt_r == '0);
  assign head    = slot_r[rd_ptr_r];
  assign do_push = push & !full;
  assign do_pop  = pop & !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= wr_cmd;
    end
  end

endmodule

[hdl/imgi_back.sv]
module imgi_back (
  input  logic                clk,
  input  logic                rst_n,
  input  imgi_pkg::cfg_t      cfg,
  input  imgi_pkg::cmd_t      cmd,
  input  logic                cmd_vld,
  output logic                cmd_pop,
  output logic                clearing,
  output imgi_pkg::out_item_t out_item,
  output logic                out_empty,
  input  logic                out_pop
);
  import imgi_pkg::*;

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
  localparam int                LO        = 2 * FRACTION_BITS;
  localparam logic [1:0]        LAST_NBR  = 2'd3;

  // word layout: {null flag, value}
  logic [VAL_W:0]            pix_mem [DEPTH];
  logic [VAL_W:0]            rd_data_r;
  logic                      mem_we;
  logic [ADDR_W-1:0]         mem_addr;
  logic [VAL_W:0]            mem_wdata, upd_word;

  state_t                    state_r, state_nxt;
  logic [ADDR_W-1:0]         clr_addr_r, clr_addr_nxt;
  logic [1:0]                cnt_r, cnt_nxt, b_k_r, b_k_nxt;
  logic                      b_vld_r, b_vld_nxt, p_vld_r, p_vld_nxt;
  logic                      nul_r, nul_nxt, res_vld_r, res_vld_nxt;
  logic signed [PROD_W-1:0]  prod_r, prod_nxt, acc_r, acc_nxt;
  out_item_t                 res_r, res_nxt;

  nbr_t                      b_nbr;
  logic                      op_null;
  logic signed [VAL_W-1:0]   op_val;
  logic signed [W_W:0]       op_wgt;
  logic                      old_null;
  logic signed [VAL_W-1:0]   old_val, sat_val;
  logic signed [VAL_W:0]     sum;
  logic                      res_free;

  assign clearing  = (state_r == ST_CLEAR);
  assign out_empty = !res_vld_r;
  assign out_item  = res_r;

  // neighbour pipeline: read -> weight multiply -> accumulate
  always_comb begin
    b_nbr     = cmd.nbr[b_k_r];
    op_null   = b_nbr.in_img ? rd_data_r[VAL_W] : cfg.outside_is_null;
    op_val    = op_null ? '0 :
                (b_nbr.in_img ? rd_data_r[VAL_W-1:0] : cfg.outside_value);
    op_wgt    = {1'b0, b_nbr.wgt};
    prod_nxt  = op_wgt * op_val;
    p_vld_nxt = b_vld_r;
  end

  // read-modify-write word for modes other than interpolate
  always_comb begin
    old_null = rd_data_r[VAL_W];
    old_val  = rd_data_r[VAL_W-1:0];
    sum      = (VAL_W+1)'(old_val) + (VAL_W+1)'(cmd.value);
    if (sum[VAL_W] != sum[VAL_W-1]) begin
      sat_val = sum[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
    end else begin
      sat_val = sum[VAL_W-1:0];
    end
    unique case (cmd.mode)
      MODE_WRITE:  upd_word = cmd.value_is_null ? {1'b1, old_val} : {old_null, cmd.value};
      MODE_INC: begin
        if (old_null) begin
          upd_word = rd_data_r;
        end else if (cmd.value_is_null) begin
          upd_word = {1'b1, old_val};
        end else begin
          upd_word = {1'b0, sat_val};
        end
      end
      MODE_NULL:   upd_word = {1'b1, old_val};
      MODE_INTERP: upd_word = rd_data_r;
      default:     upd_word = rd_data_r;
    endcase
  end

  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    cnt_nxt      = cnt_r;
    b_vld_nxt    = 1'b0;
    b_k_nxt      = cnt_r;
    nul_nxt      = nul_r | (b_vld_r & op_null & (b_nbr.wgt != '0));
    acc_nxt      = p_vld_r ? acc_r + prod_r : acc_r;
    res_free     = !res_vld_r || out_pop;
    res_vld_nxt  = res_vld_r && !out_pop;
    res_nxt      = res_r;
    cmd_pop      = 1'b0;
    mem_we       = 1'b0;
    mem_addr     = cmd.nbr[cnt_r].addr;
    mem_wdata    = upd_word;

    unique case (state_r)
      ST_CLEAR: begin
        mem_we       = 1'b1;
        mem_addr     = clr_addr_r;
        mem_wdata    = '0;
        clr_addr_nxt = clr_addr_r + ADDR_W'(1);
        if (clr_addr_r == LAST_ADDR) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (cmd_vld) begin
          if (cmd.mode == MODE_INTERP) begin
            b_vld_nxt = 1'b1;
            cnt_nxt   = cnt_r + 2'd1;
            acc_nxt   = '0;
            nul_nxt   = 1'b0;
            state_nxt = ST_INT_RD;
          end else if (cmd.nbr[0].in_img) begin
            state_nxt = ST_UPD_WR;
          end else begin
            cmd_pop = 1'b1;
          end
        end
      end
      ST_UPD_WR: begin
        mem_we    = 1'b1;
        mem_addr  = cmd.nbr[0].addr;
        cmd_pop   = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_INT_RD: begin
        b_vld_nxt = 1'b1;
        cnt_nxt   = cnt_r + 2'd1;
        if (cnt_r == LAST_NBR) begin
          state_nxt = ST_INT_END;
        end
      end
      ST_INT_END: begin
        if (!b_vld_r && !p_vld_r && res_free) begin
          res_vld_nxt            = 1'b1;
          res_nxt.interp_is_null = nul_r;
          res_nxt.interp_value   = nul_r ? '0 : acc_r[LO+VAL_W-1:LO];
          cmd_pop                = 1'b1;
          state_nxt              = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      pix_mem[mem_addr] <= mem_wdata;
    end
    rd_data_r <= pix_mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_addr_r <= '0;
      cnt_r      <= '0;
      b_vld_r    <= 1'b0;
      p_vld_r    <= 1'b0;
      res_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
      cnt_r      <= cnt_nxt;
      b_vld_r    <= b_vld_nxt;
      p_vld_r    <= p_vld_nxt;
      res_vld_r  <= res_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    b_k_r  <= b_k_nxt;
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
    nul_r  <= nul_nxt;
    res_r  <= res_nxt;
  end

endmodule

[hdl/image_store_bilinear_interp_unit.sv]
// channel  ports                                              role
// in       in_push, in_full, in_item                          item queue, write side
// out      out_empty, out_pop, out_item                       result queue, read side
// cfg      cfg_psel/penable/pwrite/paddr/pwdata/prdata/pready register access
//
// Interpolate: one item at a time, four reads of the single-port pixel memory
// pipelined into one weight multiplier and an accumulator.
// Write, increment, mark null: read-modify-write, skipped when the pixel is outside.
// After reset a clearing pass writes all 65536 memory words, one per cycle;
// in_full stays high until it ends. Register writes are taken meanwhile.
// A 2-entry command queue takes items while the back end works or a result waits.
module image_store_bilinear_interp_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  output logic                          in_full,
  input  imgi_pkg::in_item_t            in_item,
  output logic                          out_empty,
  input  logic                          out_pop,
  output imgi_pkg::out_item_t           out_item,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [imgi_pkg::PADDR_W-1:0]  cfg_paddr,
  input  logic [imgi_pkg::PDATA_W-1:0]  cfg_pwdata,
  output logic [imgi_pkg::PDATA_W-1:0]  cfg_prdata,
  output logic                          cfg_pready
);
  import imgi_pkg::*;

  cfg_t cfg;
  cmd_t front_cmd, q_head;
  logic q_full, q_empty, q_push, q_pop, clearing;

  assign in_full = q_full | clearing;
  assign q_push  = in_push & !in_full;

  imgi_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  imgi_front u_front (
    .in_item (in_item),
    .cfg     (cfg),
    .cmd     (front_cmd)
  );

  imgi_cmdq u_cmdq (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wr_cmd (front_cmd),
    .full   (q_full),
    .pop    (q_pop),
    .head   (q_head),
    .empty  (q_empty)
  );

  imgi_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .cmd       (q_head),
    .cmd_vld   (!q_empty),
    .cmd_pop   (q_pop),
    .clearing  (clearing),
    .out_item  (out_item),
    .out_empty (out_empty),
    .out_pop   (out_pop)
  );

endmodule
